/* hdl/srt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Session reverse table package
// Shared widths, operation and result codes, item types and the
// controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package srt_pkg;

  localparam int SESSIONS_DEF  = 1024;
  localparam int ROLE_BITS_DEF = 4;

  localparam int SID_W   = 10;
  localparam int IP_W    = 32;
  localparam int PORT_W  = 16;
  localparam int ROLE_W  = 4;
  localparam int OP_W    = 3;
  localparam int KIND_W  = 2;
  localparam int TUPLE_W = IP_W + 2 * PORT_W;

  localparam int S_TDATA_W = 80;
  localparam int S_TUSER_W = OP_W;
  localparam int M_TDATA_W = 128;
  localparam int M_TUSER_W = KIND_W;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_LOCAL_IP     = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_INVALID_ROLE = CFG_INDEX_W'(1);

  localparam logic [ROLE_W-1:0] INVALID_ROLE_RST = 4'hF;

  localparam logic [OP_W-1:0] OP_INSERT       = 3'd0;
  localparam logic [OP_W-1:0] OP_TUPLE_LOOKUP = 3'd1;
  localparam logic [OP_W-1:0] OP_ROLE_RX      = 3'd2;
  localparam logic [OP_W-1:0] OP_ROLE_TX      = 3'd3;
  localparam logic [OP_W-1:0] OP_RELEASE      = 3'd4;

  localparam logic [KIND_W-1:0] KIND_TUPLE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ROLE_RX = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ROLE_TX = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SID_W-1:0]  sess_id;
    logic [IP_W-1:0]   remote_ip;
    logic [PORT_W-1:0] remote_port;
    logic [PORT_W-1:0] local_port;
    logic [ROLE_W-1:0] role;
  } srt_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IP_W-1:0]   src_ip;
    logic [IP_W-1:0]   dst_ip;
    logic [PORT_W-1:0] src_port;
    logic [PORT_W-1:0] dst_port;
    logic [ROLE_W-1:0] role_out;
    logic [PORT_W-1:0] released_port_le;
    logic [SID_W-1:0]  released_session;
  } srt_result_t;

  typedef struct packed {
    logic capture;
    logic clear_en;
    logic read_en;
    logic exec;
  } srt_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic has_result;
    logic out_free;
  } srt_status_t;

  function automatic logic [PORT_W-1:0] byte_swap16(input logic [PORT_W-1:0] v);
    byte_swap16 = {v[7:0], v[15:8]};
  endfunction

endpackage

/* hdl/srt_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module srt_ram #(
  parameter int WIDTH = srt_pkg::TUPLE_W,
  parameter int DEPTH = srt_pkg::SESSIONS_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/srt_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Session reverse table controller
// Sequences the valid-bit clearing pass and the accept/read/execute steps.
// ----------------------------------------------------------------------------
module srt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  srt_pkg::srt_status_t status,
  output srt_pkg::srt_cmd_t    cmd
);

  import srt_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_EXEC  = 4'b1000
  } srt_state_t;

  srt_state_t state;
  srt_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (status.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read_en = 1'b1;
        state_next  = ST_EXEC;
      end
      ST_EXEC: begin
        // hold while a result has nowhere to go
        if (!status.has_result || status.out_free) begin
          cmd.exec   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

/* hdl/srt_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Session reverse table datapath
// Item capture, index reduction, table memories, result build and the
// output register, plus the configuration registers.
// ----------------------------------------------------------------------------
module srt_datapath #(
  parameter int SESSIONS  = srt_pkg::SESSIONS_DEF,
  parameter int ROLE_BITS = srt_pkg::ROLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  srt_pkg::srt_item_t               in_item,
  input  srt_pkg::srt_cmd_t                cmd,
  output srt_pkg::srt_status_t             status,
  input  logic                             cfg_valid,
  input  logic [srt_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [srt_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output srt_pkg::srt_result_t             out_item
);

  import srt_pkg::*;

  localparam int IDX_W    = $clog2(SESSIONS);
  localparam int RECIP_SH = 20;
  // reciprocal of the table size, exact for every 10-bit session id
  localparam int RECIP = (SESSIONS > 1023) ? 0 :
                         ((1 << RECIP_SH) + SESSIONS - 1) / SESSIONS;
  localparam int PROD_W = SID_W + RECIP_SH;
  localparam logic [SID_W-1:0] SESS_LO = SID_W'(SESSIONS);

  srt_item_t         item;
  logic [SID_W-1:0]  quot;
  logic [PROD_W-1:0] prod;
  logic [IDX_W-1:0]  idx_calc;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  clr_addr;

  logic [IP_W-1:0]   local_ip;
  logic [ROLE_W-1:0] invalid_role;

  logic [TUPLE_W-1:0]   tuple_rd;
  logic [ROLE_BITS-1:0] role_rd;
  logic                 valid_rd;

  logic [IP_W-1:0]   rd_remote_ip;
  logic [PORT_W-1:0] rd_remote_port;
  logic [PORT_W-1:0] rd_local_port;
  logic [ROLE_W-1:0] rd_role;

  logic        tbl_wr;
  logic        valid_wr;
  logic [IDX_W-1:0] valid_addr;
  logic        valid_data;
  logic        has_result;
  srt_result_t result;

  // quotient of the session id by the table size, taken at capture
  assign prod = PROD_W'(in_item.sess_id) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= in_item;
      quot <= prod[PROD_W-1:RECIP_SH];
    end
    if (cmd.read_en) begin
      idx <= idx_calc;
    end
  end

  // remainder; exact in the low bits since it stays below the table size
  assign idx_calc = IDX_W'(item.sess_id - quot * SESS_LO);

  // clearing pass over the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_en) begin
      clr_addr <= clr_addr + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      local_ip     <= '0;
      invalid_role <= INVALID_ROLE_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_LOCAL_IP) begin
        local_ip <= cfg_data;
      end else if (cfg_index == REG_INVALID_ROLE) begin
        invalid_role <= cfg_data[ROLE_W-1:0];
      end
    end
  end

  assign tbl_wr     = cmd.exec && (item.op == OP_INSERT);
  assign valid_wr   = cmd.clear_en ||
                      (cmd.exec && ((item.op == OP_INSERT) ||
                                    ((item.op == OP_RELEASE) && valid_rd)));
  assign valid_addr = cmd.clear_en ? clr_addr : idx;
  assign valid_data = !cmd.clear_en && (item.op == OP_INSERT);

  srt_ram #(.WIDTH(TUPLE_W), .DEPTH(SESSIONS)) u_tuple_ram (
    .clk     (clk),
    .wr_en   (tbl_wr),
    .wr_addr (idx),
    .wr_data ({item.local_port, item.remote_port, item.remote_ip}),
    .rd_en   (cmd.read_en),
    .rd_addr (idx_calc),
    .rd_data (tuple_rd)
  );

  srt_ram #(.WIDTH(ROLE_BITS), .DEPTH(SESSIONS)) u_role_ram (
    .clk     (clk),
    .wr_en   (tbl_wr),
    .wr_addr (idx),
    .wr_data (ROLE_BITS'(item.role)),
    .rd_en   (cmd.read_en),
    .rd_addr (idx_calc),
    .rd_data (role_rd)
  );

  srt_ram #(.WIDTH(1), .DEPTH(SESSIONS)) u_valid_ram (
    .clk     (clk),
    .wr_en   (valid_wr),
    .wr_addr (valid_addr),
    .wr_data (valid_data),
    .rd_en   (cmd.read_en),
    .rd_addr (idx_calc),
    .rd_data (valid_rd)
  );

  assign rd_remote_ip   = tuple_rd[IP_W-1:0];
  assign rd_remote_port = tuple_rd[IP_W +: PORT_W];
  assign rd_local_port  = tuple_rd[IP_W + PORT_W +: PORT_W];
  assign rd_role        = ROLE_W'(role_rd);

  always_comb begin
    result     = '0;
    has_result = 1'b0;
    unique case (item.op)
      OP_TUPLE_LOOKUP: begin
        has_result        = 1'b1;
        result.kind       = KIND_TUPLE;
        result.src_ip     = local_ip;
        result.dst_ip     = rd_remote_ip;
        result.src_port   = rd_local_port;
        result.dst_port   = rd_remote_port;
        result.role_out   = rd_role;
      end
      OP_ROLE_RX, OP_ROLE_TX: begin
        has_result        = 1'b1;
        result.kind       = (item.op == OP_ROLE_RX) ? KIND_ROLE_RX : KIND_ROLE_TX;
        result.role_out   = valid_rd ? rd_role : ROLE_W'(ROLE_BITS'(invalid_role));
      end
      OP_RELEASE: begin
        has_result              = valid_rd;
        result.kind             = KIND_RELEASE;
        result.dst_ip           = rd_remote_ip;
        result.src_port         = rd_local_port;
        result.dst_port         = rd_remote_port;
        result.released_port_le = byte_swap16(rd_local_port);
        result.released_session = item.sess_id;
      end
      default: begin
        has_result = 1'b0;
      end
    endcase
  end

  assign status.has_result = has_result;
  assign status.out_free   = !out_valid || out_ready;
  assign status.clear_done = (clr_addr == IDX_W'(SESSIONS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec && has_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && has_result) begin
      out_item <= result;
    end
  end

endmodule

/* hdl/session_reverse_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Session reverse table
// Per-session tuple and role table of a TCP engine with insert, lookup and
// release requests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_* stream: s_tuser carries the operation, s_tdata
//   the session id and the insert payload. Responses leave on the m_* stream:
//   m_tuser carries the response kind, m_tdata the tuple, role and release
//   fields. Inserts, unknown operations and releases of an idle session give
//   no response.
//   Each item passes through accept, index reduction plus table read, then
//   execute; only one item is in flight, so the write of execute lands
//   before the next item reads the table.
//   A response is registered and appears on m_* in the cycle after execute.
//   After reset the block sweeps the valid bits of all SESSIONS entries, one
//   session per cycle; s_tready stays low during that pass. The cfg_* channel
//   is always ready and writes local_ip (index 0) or invalid_role (index 1).
//   When the receiver stalls, the finished response waits in the output
//   register while the next item is accepted and read; if that item has a
//   response, it then holds in execute until the output register frees.
// ----------------------------------------------------------------------------
module session_reverse_table #(
  parameter int SESSIONS  = srt_pkg::SESSIONS_DEF,
  parameter int ROLE_BITS = srt_pkg::ROLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // request stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // sess_id[9:0], remote_ip[41:10], remote_port[57:42],
  // local_port[73:58], role[77:74], zero fill[79:78]
  input  logic [srt_pkg::S_TDATA_W-1:0]   s_tdata,
  // op[2:0]
  input  logic [srt_pkg::S_TUSER_W-1:0]   s_tuser,
  // response stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // src_ip[31:0], dst_ip[63:32], src_port[79:64], dst_port[95:80],
  // role_out[99:96], released_port_le[115:100], released_session[125:116],
  // zero fill[127:126]
  output logic [srt_pkg::M_TDATA_W-1:0]   m_tdata,
  // kind[1:0]
  output logic [srt_pkg::M_TUSER_W-1:0]   m_tuser,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [srt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [srt_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import srt_pkg::*;

  srt_item_t   in_item;
  srt_result_t out_item;
  srt_cmd_t    cmd;
  srt_status_t status;

  // registers take a write in any cycle
  assign cfg_ready = 1'b1;

  // unpack the request item
  assign in_item.op          = s_tuser;
  assign in_item.sess_id     = s_tdata[9:0];
  assign in_item.remote_ip   = s_tdata[41:10];
  assign in_item.remote_port = s_tdata[57:42];
  assign in_item.local_port  = s_tdata[73:58];
  assign in_item.role        = s_tdata[77:74];

  srt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  srt_datapath #(
    .SESSIONS  (SESSIONS),
    .ROLE_BITS (ROLE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_item  (out_item)
  );

  // pack the response item
  assign m_tuser = out_item.kind;
  assign m_tdata = {2'b00,
                    out_item.released_session,
                    out_item.released_port_le,
                    out_item.role_out,
                    out_item.dst_port,
                    out_item.src_port,
                    out_item.dst_ip,
                    out_item.src_ip};

endmodule

/* test/tb_session_reverse_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Session reverse table testbench
// Drives insert, lookup, release and unknown requests into the table while
// both stream sides idle at random. A local copy of the table predicts every
// response, and each response is checked field by field. Register writes
// happen only when the block is drained.
// ----------------------------------------------------------------------------
module tb_session_reverse_table;
  import srt_pkg::*;

  localparam int TABLE_DEPTH  = SESSIONS_DEF;
  localparam int IDLE_PERCENT = 29;
  localparam int MAX_REPORTS  = 10;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata;
  logic [S_TUSER_W-1:0]   s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [M_TDATA_W-1:0]   m_tdata;
  logic [M_TUSER_W-1:0]   m_tuser;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  session_reverse_table dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Local copy of the table and its registers, updated as items are accepted.
  logic [IP_W-1:0]   peer_ip    [TABLE_DEPTH];
  logic [PORT_W-1:0] peer_port  [TABLE_DEPTH];
  logic [PORT_W-1:0] own_port   [TABLE_DEPTH];
  logic [ROLE_W-1:0] dest_role  [TABLE_DEPTH];
  bit                entry_live [TABLE_DEPTH];
  bit                ever_set   [TABLE_DEPTH];
  int                inserted_ids[$];
  logic [IP_W-1:0]   cur_local_ip;
  logic [ROLE_W-1:0] cur_invalid_role;

  // Responses predicted but not yet seen on the output stream, oldest first.
  srt_result_t pending_responses[$];

  // Shared between the sender and the receiver.
  bit no_idle;
  int hold_off_request;

  int mismatches;
  int responses_checked;
  int n_inserts, n_tuple, n_role, n_release, n_ignored, n_cfg_writes;

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Abort on hang; covers the valid-bit sweep after reset many times over.
  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Prediction: apply one accepted item to the local table, queue its response
  // --------------------------------------------------------------------------
  task automatic apply_request(input srt_item_t it);
    srt_result_t rsp;
    int          slot;
    rsp  = '0;
    slot = int'(it.sess_id) % TABLE_DEPTH;
    case (it.op)
      OP_INSERT: begin
        peer_ip[slot]    = it.remote_ip;
        peer_port[slot]  = it.remote_port;
        own_port[slot]   = it.local_port;
        dest_role[slot]  = it.role;
        entry_live[slot] = 1'b1;
        if (!ever_set[slot]) inserted_ids.push_back(slot);
        ever_set[slot]   = 1'b1;
        n_inserts++;
      end
      OP_TUPLE_LOOKUP: begin
        // valid bit is ignored: stored entry comes back as it is
        rsp.kind     = KIND_TUPLE;
        rsp.src_ip   = cur_local_ip;
        rsp.dst_ip   = peer_ip[slot];
        rsp.src_port = own_port[slot];
        rsp.dst_port = peer_port[slot];
        rsp.role_out = dest_role[slot];
        pending_responses.push_back(rsp);
        n_tuple++;
      end
      OP_ROLE_RX, OP_ROLE_TX: begin
        rsp.kind     = (it.op == OP_ROLE_RX) ? KIND_ROLE_RX : KIND_ROLE_TX;
        rsp.role_out = entry_live[slot] ? dest_role[slot] : cur_invalid_role;
        pending_responses.push_back(rsp);
        n_role++;
      end
      OP_RELEASE: begin
        // an idle session releases silently
        if (entry_live[slot]) begin
          entry_live[slot]      = 1'b0;
          rsp.kind              = KIND_RELEASE;
          rsp.dst_ip            = peer_ip[slot];
          rsp.src_port          = own_port[slot];
          rsp.dst_port          = peer_port[slot];
          rsp.released_port_le  = {own_port[slot][7:0], own_port[slot][15:8]};
          rsp.released_session  = it.sess_id;
          pending_responses.push_back(rsp);
        end
        n_release++;
      end
      default: n_ignored++;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Sender: offer one item, hold it until accepted
  // --------------------------------------------------------------------------
  task automatic send_request(input srt_item_t it);
    if (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.op;
    s_tdata  <= {2'b00, it.role, it.local_port, it.remote_port, it.remote_ip,
                 it.sess_id};
    do @(posedge clk); while (!s_tready);
    apply_request(it);
  endtask

  function automatic srt_item_t make_request(input logic [OP_W-1:0] op,
                                             input int sid);
    srt_item_t it;
    it.op          = op;
    it.sess_id     = SID_W'(sid);
    it.remote_ip   = $urandom();
    it.remote_port = PORT_W'($urandom());
    it.local_port  = PORT_W'($urandom());
    it.role        = ROLE_W'($urandom());
    return it;
  endfunction

  // Random item; tuple lookups only target sessions that were inserted once.
  function automatic srt_item_t random_request(input int hot_base);
    srt_item_t it;
    int        pick;
    int        sid;
    pick = $urandom_range(99);
    // most traffic hits a small group of sessions so releases find live entries
    if ($urandom_range(99) < 70) sid = (hot_base + $urandom_range(31)) % TABLE_DEPTH;
    else                         sid = $urandom_range(TABLE_DEPTH - 1);
    if (pick < 30)      it = make_request(OP_INSERT, sid);
    else if (pick < 50) it = make_request(OP_TUPLE_LOOKUP, sid);
    else if (pick < 65) it = make_request(OP_ROLE_RX, sid);
    else if (pick < 80) it = make_request(OP_ROLE_TX, sid);
    else if (pick < 95) it = make_request(OP_RELEASE, sid);
    else                it = make_request(OP_W'($urandom_range(7, 5)), sid);
    if (it.op == OP_TUPLE_LOOKUP && !ever_set[sid]) begin
      if (inserted_ids.size() == 0) it.op = OP_ROLE_RX;
      else it.sess_id = SID_W'(inserted_ids[$urandom_range(inserted_ids.size() - 1)]);
    end
    return it;
  endfunction

  // Drop valid and wait until the block has nothing left in flight.
  task automatic drain_block();
    s_tvalid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    // silent items may still sit in the pipeline after the last response
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] value);
    drain_block();
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (index == REG_LOCAL_IP) cur_local_ip = value;
    else if (index == REG_INVALID_ROLE) cur_invalid_role = value[ROLE_W-1:0];
    n_cfg_writes++;
  endtask

  task automatic set_registers(input logic [IP_W-1:0] ip,
                               input logic [CFG_DATA_W-1:0] role_code);
    write_register(REG_LOCAL_IP, ip);
    write_register(REG_INVALID_ROLE, role_code);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random ready, long hold-off on request, check every response
  // --------------------------------------------------------------------------
  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, name,
                 want, got);
    end
  endtask

  task automatic check_response();
    srt_result_t want;
    srt_result_t got;
    got.kind             = m_tuser;
    got.src_ip           = m_tdata[31:0];
    got.dst_ip           = m_tdata[63:32];
    got.src_port         = m_tdata[79:64];
    got.dst_port         = m_tdata[95:80];
    got.role_out         = m_tdata[99:96];
    got.released_port_le = m_tdata[115:100];
    got.released_session = m_tdata[125:116];
    if (pending_responses.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("[%0t] unexpected response, kind %0d", $realtime, got.kind);
    end else begin
      want = pending_responses.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("src_ip", want.src_ip, got.src_ip);
      compare_field("dst_ip", want.dst_ip, got.dst_ip);
      compare_field("src_port", want.src_port, got.src_port);
      compare_field("dst_port", want.dst_port, got.dst_port);
      compare_field("role_out", want.role_out, got.role_out);
      compare_field("released_port_le", want.released_port_le, got.released_port_le);
      compare_field("released_session", want.released_session, got.released_session);
    end
    responses_checked++;
  endtask

  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) check_response();
      if (hold_off_request != 0) begin
        stall_left       = hold_off_request;
        hold_off_request = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Fresh table, reset registers: every lookup answers the invalid role.
  task automatic test_empty_table();
    send_request(make_request(OP_ROLE_RX, 5));
    send_request(make_request(OP_ROLE_TX, TABLE_DEPTH - 1));
    send_request(make_request(OP_RELEASE, 0));
    send_request(make_request(OP_W'(5), 7));
    send_request(make_request(OP_W'(6), 8));
    send_request(make_request(OP_W'(7), TABLE_DEPTH - 1));
  endtask

  // Corner field values, byte swap on release, lookups after release.
  task automatic test_insert_release();
    srt_item_t it;
    it = '0;
    it.op = OP_INSERT;
    send_request(it);
    it = '1;
    it.op = OP_INSERT;
    send_request(it);
    it = make_request(OP_INSERT, 1);
    it.local_port = 16'h12AB;
    send_request(it);
    send_request(make_request(OP_TUPLE_LOOKUP, 0));
    send_request(make_request(OP_TUPLE_LOOKUP, TABLE_DEPTH - 1));
    send_request(make_request(OP_ROLE_RX, 0));
    send_request(make_request(OP_ROLE_TX, TABLE_DEPTH - 1));
    send_request(make_request(OP_RELEASE, TABLE_DEPTH - 1));
    send_request(make_request(OP_RELEASE, TABLE_DEPTH - 1));
    send_request(make_request(OP_RELEASE, 1));
    // released entry: role reads invalid, tuple still returns the stored data
    send_request(make_request(OP_ROLE_RX, TABLE_DEPTH - 1));
    send_request(make_request(OP_TUPLE_LOOKUP, TABLE_DEPTH - 1));
  endtask

  // Register extremes seen through the lookups.
  task automatic test_register_extremes();
    set_registers(32'hFFFF_FFFF, 32'h0);
    send_request(make_request(OP_TUPLE_LOOKUP, 0));
    send_request(make_request(OP_ROLE_RX, TABLE_DEPTH - 1));
    send_request(make_request(OP_ROLE_TX, 1));
  endtask

  // Mixed random traffic under one register setting.
  task automatic test_random_traffic(input int count, input logic [IP_W-1:0] ip,
                                     input logic [CFG_DATA_W-1:0] role_code);
    srt_item_t it;
    int        counted;
    int        hot_base;
    set_registers(ip, role_code);
    hot_base = $urandom_range(TABLE_DEPTH - 1);
    counted  = 0;
    while (counted < count) begin
      it = random_request(hot_base);
      send_request(it);
      if (it.op <= OP_RELEASE) counted++;
    end
  endtask

  // Both sides at full rate.
  task automatic test_full_rate(input int count);
    no_idle = 1'b1;
    test_random_traffic(count, $urandom(), 32'd15);
    drain_block();
    no_idle = 1'b0;
  endtask

  // Receiver holds off while lookups keep coming: the block must fill and stall.
  task automatic test_output_stall(input int count);
    srt_item_t it;
    int        sid;
    drain_block();
    no_idle          = 1'b1;
    hold_off_request = 400;
    repeat (count) begin
      sid = inserted_ids.size() != 0 ?
            inserted_ids[$urandom_range(inserted_ids.size() - 1)] : 0;
      it  = make_request($urandom_range(1) ? OP_TUPLE_LOOKUP : OP_ROLE_TX, sid);
      send_request(it);
    end
    no_idle = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst              = 1'b1;
    s_tvalid         = 1'b0;
    s_tdata          = '0;
    s_tuser          = '0;
    m_tready         = 1'b0;
    cfg_valid        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    no_idle          = 1'b0;
    hold_off_request = 0;
    mismatches       = 0;
    cur_local_ip     = '0;
    cur_invalid_role = INVALID_ROLE_RST;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      entry_live[i] = 1'b0;
      ever_set[i]   = 1'b0;
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_insert_release();
    test_register_extremes();
    test_random_traffic(350, 32'h0A00_0001, 32'd7);
    // upper data bits on the role register are outside its width
    test_random_traffic(350, $urandom(), $urandom());
    test_random_traffic(350, 32'h0, 32'd15);
    test_full_rate(150);
    test_output_stall(60);

    drain_block();
    $display("covered %0d inserts, %0d tuple and %0d role lookups, %0d releases,",
             n_inserts, n_tuple, n_role, n_release);
    $display("%0d ignored items, %0d register writes; %0d responses checked",
             n_ignored, n_cfg_writes, responses_checked);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
